// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, ignored while reset is high.
`define HRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a cause seen at one edge gives the effect at the next edge.
`define HRP_ASSERT_NEXT(label, cause, effect, msg) \
  `HRP_ASSERT(label, cause |=> effect, msg)

`endif

// ===== sv/hrp_pkg.sv =====
// Shared types and codes for the HTTP request header parser.
package hrp_pkg;

  localparam int MAX_RESULTS = 3;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URI     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_HOST    = 3'd3;
  localparam logic [2:0] KIND_AGENT   = 3'd4;
  localparam logic [2:0] KIND_LENGTH  = 3'd5;
  localparam logic [2:0] KIND_STATUS  = 3'd6;

  localparam logic [3:0] METHOD_OTHER = 4'd9;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_END = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MAX_RESULTS-1:0]    item;
  } bundle_t;

endpackage

// ===== sv/hrp_parser.sv =====
// Parse state and the per-word decode step of the HTTP request header parser.
module hrp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_in,
  input  logic             last_in,
  output hrp_pkg::bundle_t results
);
  import hrp_pkg::*;

  localparam logic [9:0] TOKEN_LIMIT = 10'd15;
  localparam logic [9:0] URI_LIMIT   = 10'd511;
  localparam logic [5:0] NAME_LIMIT  = 6'd63;
  localparam logic [8:0] HOST_LIMIT  = 9'd255;
  localparam logic [8:0] AGENT_LIMIT = 9'd255;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [63:0] VERB_TEXT [9] = '{
    "GET     ", "POST    ", "PUT     ", "DELETE  ", "HEAD    ",
    "OPTIONS ", "PATCH   ", "CONNECT ", "TRACE   "
  };
  localparam logic [2:0] VERB_LEN [9] = '{
    3'd3, 3'd4, 3'd3, 3'd6, 3'd4, 3'd7, 3'd5, 3'd7, 3'd5
  };
  localparam logic [111:0] FIELD_TEXT [3] = '{
    "host          ", "user-agent    ", "content-length"
  };
  localparam logic [3:0] FIELD_LEN [3] = '{4'd4, 4'd10, 4'd14};

  typedef enum logic [3:0] {
    PH_PRE_METHOD, PH_METHOD, PH_PRE_URI, PH_URI, PH_PRE_VER, PH_VER, PH_TAIL,
    PH_NAME, PH_VALWS, PH_VALUE, PH_SKIP, PH_DONE, PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [3:0]  cnt;
    logic        neg;
    logic        stop;
    logic [8:0]  vl;
    bundle_t     bd;
  } vctx_t;

  phase_t      phase, phase_next;
  logic [3:0]  bytes_seen, bytes_seen_next;
  logic [9:0]  tl, tl_next;
  logic [8:0]  mc, mc_next;
  logic        cr, cr_next;
  logic [5:0]  nl, nl_next;
  logic [2:0]  hc, hc_next;
  logic [8:0]  vl, vl_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  dcnt, dcnt_next;
  logic        neg, neg_next;
  logic        stop, stop_next;
  logic        closed, closed_next;

  vctx_t       work;
  logic        lf, ws, restart, skip_rest;
  logic [7:0]  lb;
  logic [2:0]  hit;
  logic [1:0]  st;

  function automatic bundle_t put_item(bundle_t bd, logic [2:0] k, logic [31:0] v,
                                       logic l);
    if (bd.cnt != 2'(MAX_RESULTS)) begin
      bd.item[bd.cnt] = '{kind: k, value: v, last: l};
      bd.cnt = bd.cnt + 2'd1;
    end
    return bd;
  endfunction

  function automatic logic [9:0] sat_tok(logic [9:0] t);
    return (t != 10'd1023) ? t + 10'd1 : t;
  endfunction

  function automatic logic [8:0] verb_match(logic [8:0] cand, logic [9:0] t, logic [7:0] b);
    for (int i = 0; i < 9; i++) begin
      if (cand[i] && (t >= {7'd0, VERB_LEN[i]} ||
          VERB_TEXT[i][{3'd7 - t[2:0], 3'b000} +: 8] != b)) begin
        cand[i] = 1'b0;
      end
    end
    return cand;
  endfunction

  function automatic logic [3:0] verb_code(logic [8:0] cand, logic [9:0] t);
    logic [3:0] code;
    code = METHOD_OTHER;
    for (int i = 8; i >= 0; i--) begin
      if (cand[i] && t == {7'd0, VERB_LEN[i]}) code = 4'(i);
    end
    return code;
  endfunction

  function automatic logic [2:0] name_match(logic [2:0] cand, logic [5:0] n, logic [7:0] c);
    for (int i = 0; i < 3; i++) begin
      if (cand[i] && (n >= {2'd0, FIELD_LEN[i]} ||
          FIELD_TEXT[i][{4'd13 - n[3:0], 3'b000} +: 8] != c)) begin
        cand[i] = 1'b0;
      end
    end
    return cand;
  endfunction

  function automatic vctx_t value_byte(vctx_t c, logic [2:0] h, logic [7:0] b);
    logic [35:0] prod;
    logic [8:0]  lim;
    prod = '0;
    lim = (h == 3'b001) ? HOST_LIMIT : AGENT_LIMIT;
    if (h == 3'b100) begin
      if (c.cnt != 4'd15 && !c.stop) begin
        if (c.cnt == 4'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
          if (b == CH_MINUS) c.neg = 1'b1;
        end else if (b >= CH_0 && b <= CH_9) begin
          prod = ({4'd0, c.acc} << 3) + ({4'd0, c.acc} << 1) + {28'd0, b - CH_0};
          c.acc = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];
        end else begin
          c.stop = 1'b1;
        end
        c.cnt = c.cnt + 4'd1;
      end
    end else begin
      if (c.vl < lim) begin
        c.bd = put_item(c.bd, (h == 3'b001) ? KIND_HOST : KIND_AGENT, {24'd0, b}, 1'b0);
      end
      if (c.vl != 9'd511) c.vl = c.vl + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [31:0] length_value(vctx_t c);
    if (c.neg) return 32'd0 - c.acc;
    return (c.acc > 32'h7FFFFFFF) ? 32'h7FFFFFFF : c.acc;
  endfunction

  always_comb begin
    phase_next      = phase;
    bytes_seen_next = (bytes_seen < 4'd14) ? bytes_seen + 4'd1 : bytes_seen;
    tl_next         = tl;
    mc_next         = mc;
    cr_next         = cr;
    nl_next         = nl;
    hc_next         = hc;
    closed_next     = closed;
    work            = '{acc: acc, cnt: dcnt, neg: neg, stop: stop, vl: vl, bd: '0};
    restart         = 1'b0;
    skip_rest       = 1'b0;
    hit             = 3'b000;
    st              = STATUS_OK;
    lf              = (byte_in == CH_LF);
    ws              = byte_in inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    lb              = (byte_in >= 8'h41 && byte_in <= 8'h5A) ? byte_in + 8'h20 : byte_in;

    case (phase)
      PH_PRE_METHOD: begin
        if (lf) begin
          phase_next = PH_FAIL;
        end else if (!ws) begin
          phase_next = PH_METHOD;
          mc_next = verb_match(mc, 10'd0, byte_in);
          tl_next = 10'd1;
        end
      end
      PH_METHOD: begin
        if (lf || ws) begin
          work.bd = put_item(work.bd, KIND_METHOD, {28'd0, verb_code(mc, tl)}, 1'b0);
          tl_next = 10'd0;
          phase_next = lf ? PH_FAIL : PH_PRE_URI;
        end else begin
          mc_next = verb_match(mc, tl, byte_in);
          tl_next = sat_tok(tl);
        end
      end
      PH_PRE_URI: begin
        if (lf) begin
          phase_next = PH_FAIL;
        end else if (!ws) begin
          phase_next = PH_URI;
          work.bd = put_item(work.bd, KIND_URI, {24'd0, byte_in}, 1'b0);
          tl_next = 10'd1;
        end
      end
      PH_URI: begin
        if (lf) begin
          phase_next = PH_FAIL;
        end else if (ws) begin
          phase_next = PH_PRE_VER;
          tl_next = 10'd0;
        end else begin
          if (tl < URI_LIMIT) begin
            work.bd = put_item(work.bd, KIND_URI, {24'd0, byte_in}, 1'b0);
          end
          tl_next = sat_tok(tl);
        end
      end
      PH_PRE_VER: begin
        if (lf) begin
          phase_next = PH_FAIL;
        end else if (!ws) begin
          phase_next = PH_VER;
          work.bd = put_item(work.bd, KIND_VERSION, {24'd0, byte_in}, 1'b0);
          tl_next = 10'd1;
        end
      end
      PH_VER: begin
        if (lf) begin
          restart = 1'b1;
        end else if (ws) begin
          phase_next = PH_TAIL;
        end else begin
          if (tl < TOKEN_LIMIT) begin
            work.bd = put_item(work.bd, KIND_VERSION, {24'd0, byte_in}, 1'b0);
          end
          tl_next = sat_tok(tl);
        end
      end
      PH_TAIL: begin
        if (lf) restart = 1'b1;
      end
      PH_NAME: begin
        if (cr) begin
          cr_next = 1'b0;
          if (lf) begin
            closed_next = 1'b1;
            phase_next = PH_DONE;
            skip_rest = 1'b1;
          end else begin
            nl_next = 6'd1;
            hc_next = 3'b000;
          end
        end
        if (!skip_rest) begin
          if (lf) begin
            if (nl_next == 6'd0) begin
              closed_next = 1'b1;
              phase_next = PH_DONE;
            end else begin
              restart = 1'b1;
            end
          end else if (byte_in == CH_CR && nl_next == 6'd0) begin
            cr_next = 1'b1;
          end else if (byte_in == CH_COLON) begin
            for (int i = 0; i < 3; i++) begin
              if (hc_next[i] && nl_next == {2'd0, FIELD_LEN[i]}) hit[i] = 1'b1;
            end
            hc_next = hit;
            phase_next = (hit != 3'b000) ? PH_VALWS : PH_SKIP;
          end else begin
            hc_next = name_match(hc_next, nl_next, lb);
            if (nl_next < NAME_LIMIT) nl_next = nl_next + 6'd1;
          end
        end
      end
      PH_VALWS: begin
        if (lf) begin
          if (hc == 3'b100) begin
            work.bd = put_item(work.bd, KIND_LENGTH, length_value(work), 1'b0);
          end
          restart = 1'b1;
        end else if (!ws) begin
          phase_next = PH_VALUE;
          work = value_byte(work, hc, byte_in);
        end
      end
      PH_VALUE: begin
        if (cr) begin
          cr_next = 1'b0;
          if (lf) begin
            skip_rest = 1'b1;
          end else begin
            work = value_byte(work, hc, CH_CR);
          end
        end
        if (lf) begin
          if (hc == 3'b100) begin
            work.bd = put_item(work.bd, KIND_LENGTH, length_value(work), 1'b0);
          end
          restart = 1'b1;
        end else if (!skip_rest && byte_in == CH_CR) begin
          cr_next = 1'b1;
        end else if (!skip_rest) begin
          work = value_byte(work, hc, byte_in);
        end
      end
      PH_SKIP: begin
        if (lf) restart = 1'b1;
      end
      PH_DONE, PH_FAIL: begin
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase

    if (restart) begin
      phase_next = PH_NAME;
      nl_next = 6'd0;
      hc_next = 3'b111;
      cr_next = 1'b0;
      work.vl = 9'd0;
      work.acc = 32'd0;
      work.cnt = 4'd0;
      work.neg = 1'b0;
      work.stop = 1'b0;
    end

    if (last_in) begin
      if (bytes_seen_next < 4'd14 || phase_next <= PH_TAIL || phase_next == PH_FAIL) begin
        st = STATUS_ERROR;
      end else if (!closed_next) begin
        st = STATUS_NO_END;
      end
      work.bd = put_item(work.bd, KIND_STATUS, {30'd0, st}, 1'b1);
      phase_next = PH_PRE_METHOD;
      bytes_seen_next = 4'd0;
      tl_next = 10'd0;
      mc_next = 9'h1FF;
      cr_next = 1'b0;
      nl_next = 6'd0;
      hc_next = 3'b111;
      closed_next = 1'b0;
      work.vl = 9'd0;
      work.acc = 32'd0;
      work.cnt = 4'd0;
      work.neg = 1'b0;
      work.stop = 1'b0;
    end

    vl_next   = work.vl;
    acc_next  = work.acc;
    dcnt_next = work.cnt;
    neg_next  = work.neg;
    stop_next = work.stop;
    results   = work.bd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PRE_METHOD;
      bytes_seen <= 4'd0;
      tl         <= 10'd0;
      mc         <= 9'h1FF;
      cr         <= 1'b0;
      nl         <= 6'd0;
      hc         <= 3'b111;
      vl         <= 9'd0;
      acc        <= 32'd0;
      dcnt       <= 4'd0;
      neg        <= 1'b0;
      stop       <= 1'b0;
      closed     <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_seen <= bytes_seen_next;
      tl         <= tl_next;
      mc         <= mc_next;
      cr         <= cr_next;
      nl         <= nl_next;
      hc         <= hc_next;
      vl         <= vl_next;
      acc        <= acc_next;
      dcnt       <= dcnt_next;
      neg        <= neg_next;
      stop       <= stop_next;
      closed     <= closed_next;
    end
  end

endmodule

// ===== sv/hrp_outq.sv =====
// Four-entry result queue that takes up to three results per input word.
module hrp_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  hrp_pkg::bundle_t wr_bundle,
  output logic             wr_ready,
  output logic             rd_valid,
  input  logic             rd_ready,
  output hrp_pkg::result_t rd_item
);
  import hrp_pkg::*;

  result_t    slot [4];
  logic [1:0] wp, rp;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop        = rd_valid && rd_ready;
  assign rd_valid   = (count != 3'd0);
  assign rd_item    = slot[rp];
  assign wr_ready   = (count <= 3'd1);
  assign count_next = count + (wr_en ? {1'b0, wr_bundle.cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 3'd0;
    end else begin
      if (wr_en) wp <= wp + wr_bundle.cnt;
      if (pop) rp <= rp + 2'd1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (2'(k) < wr_bundle.cnt) slot[wp + 2'(k)] <= wr_bundle.item[k];
      end
    end
  end

endmodule

// ===== sv/http_request_header_parser_top.sv =====
// Top level of the HTTP request header parser: byte stream in, parsed items out.
// When the queue is empty, an accepted word's first result is on the output in the cycle after the word is accepted.
// Throughput: one word per cycle while each word yields at most one result and m_tready
// stays high; a word with two or three results blocks the input until the queue holds at most one result.
// Reset: rst clears the parse state to the start of a request and empties the queue.
module http_request_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] item_value
  output logic [2:0]  m_tuser,   // [2:0] item_kind
  output logic        m_tlast
);
  import hrp_pkg::*;

  bundle_t step_results;
  result_t out_item;
  logic    in_accept;

  assign in_accept = s_tvalid && s_tready;

  hrp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .byte_in (s_tdata),
    .last_in (s_tlast),
    .results (step_results)
  );

  hrp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_accept),
    .wr_bundle (step_results),
    .wr_ready  (s_tready),
    .rd_valid  (m_tvalid),
    .rd_ready  (m_tready),
    .rd_item   (out_item)
  );

  assign m_tdata = out_item.value;
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last;

endmodule

// ===== sv/hrp_checker.sv =====
// Port-level assertions for the HTTP request header parser and their binding.
`include "assert_macros.svh"

module hrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import hrp_pkg::*;

  `HRP_ASSERT(a_last_is_status, m_tvalid && m_tlast |-> m_tuser == KIND_STATUS, "tlast on a word that is not a status")
  `HRP_ASSERT(a_status_form, m_tvalid && m_tuser == KIND_STATUS |-> m_tlast && m_tdata[31:2] == 30'd0 && m_tdata[1:0] <= STATUS_ERROR, "malformed status word")
  `HRP_ASSERT(a_value_range, m_tvalid && (m_tuser == KIND_URI || m_tuser == KIND_VERSION || m_tuser == KIND_HOST || m_tuser == KIND_AGENT) |-> m_tdata[31:8] == 24'd0, "byte word wider than a byte")
  `HRP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")

endmodule

bind http_request_header_parser_top hrp_checker u_hrp_checker (.*);

// ===== tb/hrp_request_checker.sv =====
// Checker for the HTTP request header parser: predicts parsed items and compares them.
module hrp_request_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;

  localparam int VERSION_MAX = 15;
  localparam int URI_MAX     = 511;
  localparam int NAME_MAX    = 63;
  localparam int HOST_MAX    = 255;
  localparam int AGENT_MAX   = 255;
  localparam int VALUE_SAT   = 511;
  localparam int TOKEN_SAT   = 1023;
  localparam int DIGITS_MAX  = 15;
  localparam int MIN_BYTES   = 14;

  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] VT_CHAR    = 8'h0B;
  localparam logic [7:0] FF_CHAR    = 8'h0C;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [2:0] ONLY_HOST   = 3'b001;
  localparam logic [2:0] ONLY_LENGTH = 3'b100;
  localparam logic [2:0] ALL_FIELDS  = 3'b111;
  localparam logic [8:0] ALL_VERBS   = 9'h1FF;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    SEEK_METHOD, IN_METHOD, SEEK_URI, IN_URI, SEEK_VERSION, IN_VERSION, LINE_TAIL,
    HDR_NAME, HDR_GAP, HDR_VALUE, HDR_SKIP, HDR_DONE, REQ_BAD
  } parse_phase_t;

  string verb_text [9] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS", "PATCH",
                           "CONNECT", "TRACE"};
  string field_text [3] = '{"host", "user-agent", "content-length"};

  parse_phase_t phase;
  int           byte_cnt;
  int           tok_len;
  logic [8:0]   verb_live;
  logic         cr_held;
  int           name_count;
  logic [2:0]   field_live;
  int           val_len;
  logic [31:0]  magnitude;
  int           num_cnt;
  logic         num_neg;
  logic         num_stop;
  logic         hdr_closed;

  result_t parsed_items_due [$];
  int      items_this_word;
  int      fail_count = 0;

  function automatic void add_item(logic [2:0] kind, logic [31:0] value, logic last);
    result_t r;
    if (items_this_word >= MAX_RESULTS) return;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    parsed_items_due.push_back(r);
    items_this_word++;
  endfunction

  function automatic void start_header_line();
    phase      = HDR_NAME;
    name_count = 0;
    field_live = ALL_FIELDS;
    val_len    = 0;
    magnitude  = '0;
    num_cnt    = 0;
    num_neg    = 1'b0;
    num_stop   = 1'b0;
    cr_held    = 1'b0;
  endfunction

  function automatic void restart_request();
    start_header_line();
    phase      = SEEK_METHOD;
    byte_cnt   = 0;
    tok_len    = 0;
    verb_live  = ALL_VERBS;
    hdr_closed = 1'b0;
  endfunction

  function automatic void feed_verb(logic [7:0] b);
    int i;
    for (i = 0; i < 9; i++) begin
      if (verb_live[i] && (tok_len >= verb_text[i].len() || verb_text[i][tok_len] != b))
        verb_live[i] = 1'b0;
    end
    if (tok_len < TOKEN_SAT) tok_len++;
  endfunction

  function automatic logic [31:0] verb_code();
    int i;
    for (i = 0; i < 9; i++) begin
      if (verb_live[i] && verb_text[i].len() == tok_len) return 32'(i);
    end
    return 32'(METHOD_OTHER);
  endfunction

  function automatic void token_byte(logic [2:0] kind, int limit, logic [7:0] b);
    if (tok_len < limit) add_item(kind, 32'(b), 1'b0);
    if (tok_len < TOKEN_SAT) tok_len++;
  endfunction

  function automatic void feed_name(logic [7:0] b);
    logic [7:0] lb;
    int i;
    lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    for (i = 0; i < 3; i++) begin
      if (field_live[i] &&
          (name_count >= field_text[i].len() || field_text[i][name_count] != lb))
        field_live[i] = 1'b0;
    end
    if (name_count < NAME_MAX) name_count++;
  endfunction

  function automatic void feed_digit(logic [7:0] b);
    logic [63:0] v;
    if (num_cnt >= DIGITS_MAX || num_stop) return;
    if (num_cnt == 0 && (b == "+" || b == "-")) begin
      if (b == "-") num_neg = 1'b1;
    end else if (b >= "0" && b <= "9") begin
      v = {32'd0, magnitude} * 64'd10 + 64'(b - 8'd48);
      magnitude = (v > 64'(MAG_CAP)) ? MAG_CAP : v[31:0];
    end else begin
      num_stop = 1'b1;
    end
    num_cnt++;
  endfunction

  function automatic void value_byte(logic [7:0] b);
    if (field_live == ONLY_LENGTH) begin
      feed_digit(b);
      return;
    end
    if (val_len < ((field_live == ONLY_HOST) ? HOST_MAX : AGENT_MAX))
      add_item((field_live == ONLY_HOST) ? KIND_HOST : KIND_AGENT, 32'(b), 1'b0);
    if (val_len < VALUE_SAT) val_len++;
  endfunction

  function automatic void finish_header_line();
    logic [31:0] v;
    if (field_live == ONLY_LENGTH) begin
      if (num_neg) v = 32'd0 - magnitude;
      else v = (magnitude > POS_MAX) ? POS_MAX : magnitude;
      add_item(KIND_LENGTH, v, 1'b0);
    end
    start_header_line();
  endfunction

  function automatic void parse_request_byte(logic [7:0] b, logic eop);
    logic       lf;
    logic       ws;
    logic       handled;
    logic [2:0] hit;
    logic [1:0] st;
    int         i;
    lf = (b == LF_CHAR);
    ws = (b == SPACE_CHAR || b == TAB_CHAR || b == VT_CHAR || b == FF_CHAR || b == CR_CHAR);
    handled = 1'b0;
    items_this_word = 0;
    if (byte_cnt < MIN_BYTES) byte_cnt++;
    case (phase)
      SEEK_METHOD: begin
        if (lf) phase = REQ_BAD;
        else if (!ws) begin
          phase = IN_METHOD;
          tok_len = 0;
          feed_verb(b);
        end
      end
      IN_METHOD: begin
        if (lf || ws) begin
          add_item(KIND_METHOD, verb_code(), 1'b0);
          tok_len = 0;
          if (lf) phase = REQ_BAD;
          else phase = SEEK_URI;
        end else feed_verb(b);
      end
      SEEK_URI: begin
        if (lf) phase = REQ_BAD;
        else if (!ws) begin
          phase = IN_URI;
          tok_len = 0;
          token_byte(KIND_URI, URI_MAX, b);
        end
      end
      IN_URI: begin
        if (lf) phase = REQ_BAD;
        else if (ws) begin
          phase = SEEK_VERSION;
          tok_len = 0;
        end else token_byte(KIND_URI, URI_MAX, b);
      end
      SEEK_VERSION: begin
        if (lf) phase = REQ_BAD;
        else if (!ws) begin
          phase = IN_VERSION;
          tok_len = 0;
          token_byte(KIND_VERSION, VERSION_MAX, b);
        end
      end
      IN_VERSION: begin
        if (lf) start_header_line();
        else if (ws) phase = LINE_TAIL;
        else token_byte(KIND_VERSION, VERSION_MAX, b);
      end
      LINE_TAIL: begin
        if (lf) start_header_line();
      end
      HDR_NAME: begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (lf) begin
            hdr_closed = 1'b1;
            phase = HDR_DONE;
            handled = 1'b1;
          end else begin
            name_count = 1;
            field_live = '0;
          end
        end
        if (!handled) begin
          if (lf) begin
            if (name_count == 0) begin
              hdr_closed = 1'b1;
              phase = HDR_DONE;
            end else start_header_line();
          end else if (b == CR_CHAR && name_count == 0) begin
            cr_held = 1'b1;
          end else if (b == ":") begin
            hit = '0;
            for (i = 0; i < 3; i++) begin
              if (field_live[i] && name_count == field_text[i].len()) hit = 3'b001 << i;
            end
            field_live = hit;
            if (hit != '0) phase = HDR_GAP;
            else phase = HDR_SKIP;
          end else feed_name(b);
        end
      end
      HDR_GAP: begin
        if (lf) finish_header_line();
        else if (!ws) begin
          phase = HDR_VALUE;
          value_byte(b);
        end
      end
      HDR_VALUE: begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (lf) begin
            finish_header_line();
            handled = 1'b1;
          end else value_byte(CR_CHAR);
        end
        if (!handled) begin
          if (lf) finish_header_line();
          else if (b == CR_CHAR) cr_held = 1'b1;
          else value_byte(b);
        end
      end
      HDR_SKIP: begin
        if (lf) start_header_line();
      end
      default: ;
    endcase

    if (eop) begin
      if (byte_cnt < MIN_BYTES || phase <= LINE_TAIL || phase == REQ_BAD) st = STATUS_ERROR;
      else if (!hdr_closed) st = STATUS_NO_END;
      else st = STATUS_OK;
      add_item(KIND_STATUS, 32'(st), 1'b1);
      restart_request();
    end
  endfunction

  function automatic void check_parsed_item();
    result_t due;
    if (parsed_items_due.size() == 0) begin
      $error("Unexpected item: item_kind %0d, item_value %0d, last_of_message %0b",
             m_tuser, $signed(m_tdata), m_tlast);
      fail_count++;
      return;
    end
    due = parsed_items_due.pop_front();
    if (m_tuser !== due.kind) begin
      $error("item_kind: expected %0d, actual %0d", due.kind, m_tuser);
      fail_count++;
    end
    if (m_tdata !== due.value) begin
      $error("item_value: expected %0d, actual %0d", $signed(due.value), $signed(m_tdata));
      fail_count++;
    end
    if (m_tlast !== due.last) begin
      $error("last_of_message: expected %0b, actual %0b", due.last, m_tlast);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_request();
      parsed_items_due.delete();
    end else begin
      if (s_tvalid && s_tready) parse_request_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_parsed_item();
    end
    errors  <= fail_count;
    pending <= parsed_items_due.size();
  end

endmodule

// ===== tb/http_request_header_parser_top_tb.sv =====
// Testbench top for the HTTP request header parser: request stimulus, clock, reset and verdict.
module http_request_header_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 50;
  localparam int STEADY_AFTER = 25;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] VT_CHAR    = 8'h0B;
  localparam logic [7:0] FF_CHAR    = 8'h0C;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  int chk_errors;
  int chk_pending;
  int cycles = 0;
  bit steady = 1'b0;
  int random_sent = 0;

  string verb_names [9] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS", "PATCH",
                            "CONNECT", "TRACE"};
  bit [7:0] request_bytes [$];

  http_request_header_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  hrp_request_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (chk_errors),
    .pending  (chk_pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    forever begin
      if (steady || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endfunction

  function automatic bit is_separator(bit [7:0] c);
    return c == SPACE_CHAR || c == TAB_CHAR || c == VT_CHAR || c == FF_CHAR ||
           c == CR_CHAR || c == LF_CHAR;
  endfunction

  function automatic bit [7:0] token_char(bit any_byte);
    bit [7:0] c;
    do begin
      if (any_byte) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(33, 126));
    end while (is_separator(c));
    return c;
  endfunction

  function automatic void add_gap();
    int sel;
    repeat ($urandom_range(1, 2)) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: request_bytes.push_back(TAB_CHAR);
        1: request_bytes.push_back(VT_CHAR);
        2: request_bytes.push_back(FF_CHAR);
        3: request_bytes.push_back(CR_CHAR);
        default: request_bytes.push_back(SPACE_CHAR);
      endcase
    end
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 2) != 0) request_bytes.push_back(CR_CHAR);
    request_bytes.push_back(LF_CHAR);
  endfunction

  function automatic string mix_case(string s);
    string t;
    bit [7:0] c;
    int i;
    t = s;
    for (i = 0; i < t.len(); i++) begin
      c = t[i];
      if ($urandom_range(0, 1) != 0) begin
        if (c >= "a" && c <= "z") c = c - 8'd32;
        else if (c >= "A" && c <= "Z") c = c + 8'd32;
      end
      t.putc(i, c);
    end
    return t;
  endfunction

  function automatic void add_header_line();
    int sel;
    sel = $urandom_range(0, 6);
    case (sel)
      0: add_text(mix_case("Host"));
      1: add_text(mix_case("User-Agent"));
      2, 3: add_text(mix_case("Content-Length"));
      4: repeat ($urandom_range(1, 12)) request_bytes.push_back(8'($urandom_range(97, 122)));
      5: begin
        repeat ($urandom_range(1, 10)) request_bytes.push_back(token_char(1'b0));
        add_eol();
        return;
      end
      default: begin
        request_bytes.push_back(CR_CHAR);
        repeat ($urandom_range(1, 6)) request_bytes.push_back(token_char(1'b0));
        add_eol();
        return;
      end
    endcase
    if ($urandom_range(0, 9) == 0) request_bytes.push_back(SPACE_CHAR);
    request_bytes.push_back(":");
    repeat ($urandom_range(0, 2))
      request_bytes.push_back(($urandom_range(0, 1) != 0) ? SPACE_CHAR : TAB_CHAR);
    if (sel == 2 || sel == 3) begin
      case ($urandom_range(0, 3))
        0: request_bytes.push_back("+");
        1: request_bytes.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(0, 12)) request_bytes.push_back(8'($urandom_range(48, 57)));
      if ($urandom_range(0, 4) == 0) begin
        request_bytes.push_back(token_char(1'b0));
        repeat ($urandom_range(0, 3)) request_bytes.push_back(8'($urandom_range(48, 57)));
      end
    end else begin
      repeat ($urandom_range(0, 10)) begin
        request_bytes.push_back(token_char($urandom_range(0, 5) == 0));
        if ($urandom_range(0, 9) == 0) request_bytes.push_back(CR_CHAR);
      end
    end
    add_eol();
  endfunction

  function automatic void build_random_request();
    int sel;
    int keep;
    if ($urandom_range(0, 9) == 0) add_gap();
    sel = $urandom_range(0, 11);
    if (sel < 9) add_text(verb_names[sel]);
    else if (sel == 9) add_text(mix_case(verb_names[$urandom_range(0, 8)]));
    else repeat ($urandom_range(1, 18)) request_bytes.push_back(token_char(1'b0));
    add_gap();
    repeat ($urandom_range(1, 8)) request_bytes.push_back(token_char($urandom_range(0, 3) == 0));
    if ($urandom_range(0, 11) != 0) begin
      add_gap();
      sel = $urandom_range(0, 5);
      if (sel < 3) add_text("HTTP/1.1");
      else if (sel == 3) add_text("HTTP/1.0");
      else repeat ($urandom_range(1, 20)) request_bytes.push_back(token_char(1'b0));
      if ($urandom_range(0, 5) == 0) begin
        add_gap();
        repeat ($urandom_range(1, 4)) request_bytes.push_back(token_char(1'b0));
      end
    end
    add_eol();
    repeat ($urandom_range(0, 3)) add_header_line();
    if ($urandom_range(0, 5) != 0) begin
      add_eol();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) request_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, request_bytes.size());
      while (request_bytes.size() > keep) void'(request_bytes.pop_back());
    end
  endfunction

  task automatic send_request_bytes();
    int i;
    for (i = 0; i < request_bytes.size(); i++) begin
      if (!steady && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= request_bytes[i];
      s_tlast  <= (i == request_bytes.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    request_bytes.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_request_bytes();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text({"\tGET /i HTTP/1.1-and-more\015\n", "hOsT:  ex\015\n",
               "USER-AGENT:\tab\015cd\015\n", "Content-Length: +42\015\n",
               "no colon\015\n", "\015x: y\015\n", "Host : skip\015\n", "\015\nBODY\n"});
    send_text({"PUT / H\ncontent-length: 99999999999\n",
               "Content-Length:-2147483648\nContent-Length: 7x\n\n"});
    send_text("DELETE\nHost: xyzw\n\n");
    send_text("G");
    send_text("GET / HTTP/1.1");
    add_text("GET /");
    request_bytes.push_back(8'hFF);
    send_text(" HTTP/1.1\n\015\n");

    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 24)) begin
          if ($urandom_range(0, 7) == 0) request_bytes.push_back(LF_CHAR);
          else request_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        build_random_request();
      end
      random_sent += request_bytes.size();
      if (random_sent > STEADY_AFTER) steady = 1'b1;
      send_request_bytes();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
